// File: src/ign3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ign3_pkg: shared constants and helpers for 3D improved gradient noise
// Permutation table lookup and the stream handshake type.
// ----------------------------------------------------------------------------
package ign3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LATTICE_SIZE  = 256;
    localparam int COORD_W       = 32;
    localparam int OUT_W         = 18;
    localparam int IDX_W         = 8;
    localparam int HASH_W        = 9;

    // Standard reference permutation; the doubled table is perm(i mod 256).
    function automatic logic [7:0] perm_rom(input logic [7:0] i);
        logic [7:0] r;
        unique case (i)
            8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
            8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
            8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
            8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
            8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
            8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
            8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
            8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
            8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
            8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
            8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
            8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
            8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
            8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
            8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
            8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
            8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
            8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
            8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
            8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
            8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
            8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
            8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
            8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
            8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
            8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
            8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
            8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
            8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
            8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
            8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
            8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
            8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
            8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
            8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
            8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
            8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
            8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
            8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
            8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
            8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
            8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
            8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
            8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
            8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
            8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
            8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
            8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
            8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
            8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
            8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
            8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
            8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
            8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
            8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
            8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
            8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
            8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
            8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
            8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
            8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
            8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
            8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
            8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Doubled table: entries 256..511 repeat 0..255.
    function automatic logic [7:0] perm9(input logic [HASH_W-1:0] i);
        return perm_rom(i[7:0]);
    endfunction

    // Stream control pair; the top level holds its output valid and ready in it.
    typedef struct packed {
        logic valid;
        logic ready;
    } ign3_hs_t;

endpackage

// File: src/ign3_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ign3_hash: lattice hashing and fraction fade
// Three registered stages of permutation lookups; fade curve in parallel.
// ----------------------------------------------------------------------------
module ign3_hash #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ign3_pkg::COORD_W-1:0]  in_x,
    input  logic [ign3_pkg::COORD_W-1:0]  in_y,
    input  logic [ign3_pkg::COORD_W-1:0]  in_z,
    output logic                          out_valid,
    output logic [7:0]                    out_hash [8],
    output logic [FRAC_BITS-1:0]          out_fx,
    output logic [FRAC_BITS-1:0]          out_fy,
    output logic [FRAC_BITS-1:0]          out_fz,
    output logic [FRAC_BITS:0]            out_u,
    output logic [FRAC_BITS:0]            out_v,
    output logic [FRAC_BITS:0]            out_w
);
    import ign3_pkg::*;

    localparam int F = FRAC_BITS;
    localparam int TW = 2 * F;
    localparam int CW = F + 5;

    // stage 1
    logic          v1_reg;
    logic [7:0]    y1_reg, z1_reg, pa1_reg, pb1_reg;
    logic [F-1:0]  fx1_reg, fy1_reg, fz1_reg;
    logic [F-1:0]  t2_1_reg [3];
    // stage 2
    logic          v2_reg;
    logic [7:0]    z2_reg;
    logic [HASH_W-1:0] h2_reg [4];
    logic [F-1:0]  fx2_reg, fy2_reg, fz2_reg;
    logic [F-1:0]  t3_2_reg [3];
    logic [CW-1:0] c2_reg [3];
    // stage 3
    logic          v3_reg;
    logic [7:0]    hash3_reg [8];
    logic [F-1:0]  fx3_reg, fy3_reg, fz3_reg;
    logic [F:0]    fade3_reg [3];

    logic [F-1:0]  fr [3];
    logic [F-1:0]  fr2 [3];

    always_comb begin
        fr[0] = in_x[F-1:0];
        fr[1] = in_y[F-1:0];
        fr[2] = in_z[F-1:0];
        fr2[0] = fx1_reg;
        fr2[1] = fy1_reg;
        fr2[2] = fz1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [TW-1:0]       sq;
        logic [TW-1:0]       cu;
        logic signed [CW:0]  cc;
        logic [HASH_W-1:0]   a9, b9;
        logic [2*CW-1:0]     pr;
        if (en) begin
            // stage 1: A and B roots, t^2
            pa1_reg <= perm_rom(in_x[F+7:F]);
            pb1_reg <= perm_rom(in_x[F+7:F] + 8'd1);
            y1_reg  <= in_y[F+7:F];
            z1_reg  <= in_z[F+7:F];
            fx1_reg <= fr[0];
            fy1_reg <= fr[1];
            fz1_reg <= fr[2];
            for (int i = 0; i < 3; i++) begin
                sq = TW'(fr[i]) * TW'(fr[i]);
                t2_1_reg[i] <= sq[TW-1:F];
            end
            // stage 2: AA, AB, BA, BB; t^3 and quintic coefficient
            a9 = HASH_W'(pa1_reg) + HASH_W'(y1_reg);
            b9 = HASH_W'(pb1_reg) + HASH_W'(y1_reg);
            h2_reg[0] <= HASH_W'(perm9(a9)) + HASH_W'(z1_reg);
            h2_reg[1] <= HASH_W'(perm9(a9 + 9'd1)) + HASH_W'(z1_reg);
            h2_reg[2] <= HASH_W'(perm9(b9)) + HASH_W'(z1_reg);
            h2_reg[3] <= HASH_W'(perm9(b9 + 9'd1)) + HASH_W'(z1_reg);
            z2_reg  <= z1_reg;
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
            fz2_reg <= fz1_reg;
            for (int i = 0; i < 3; i++) begin
                cu = TW'(t2_1_reg[i]) * TW'(fr2[i]);
                t3_2_reg[i] <= cu[TW-1:F];
                cc = (CW+1)'(6) * $signed({1'b0, (CW)'(t2_1_reg[i])})
                   - (CW+1)'(15) * $signed({1'b0, (CW)'(fr2[i])})
                   + $signed((CW+1)'(10) <<< F);
                c2_reg[i] <= cc[CW] ? '0 : cc[CW-1:0];
            end
            // stage 3: corner hashes and fade
            hash3_reg[0] <= perm9(h2_reg[0]);        // AA
            hash3_reg[1] <= perm9(h2_reg[2]);        // BA
            hash3_reg[2] <= perm9(h2_reg[1]);        // AB
            hash3_reg[3] <= perm9(h2_reg[3]);        // BB
            hash3_reg[4] <= perm9(h2_reg[0] + 9'd1);
            hash3_reg[5] <= perm9(h2_reg[2] + 9'd1);
            hash3_reg[6] <= perm9(h2_reg[1] + 9'd1);
            hash3_reg[7] <= perm9(h2_reg[3] + 9'd1);
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
            fz3_reg <= fz2_reg;
            for (int i = 0; i < 3; i++) begin
                pr = (2*CW)'(t3_2_reg[i]) * (2*CW)'(c2_reg[i]);
                fade3_reg[i] <= pr[F+F:F];
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_hash  = hash3_reg;
    assign out_fx    = fx3_reg;
    assign out_fy    = fy3_reg;
    assign out_fz    = fz3_reg;
    assign out_u     = fade3_reg[0];
    assign out_v     = fade3_reg[1];
    assign out_w     = fade3_reg[2];

endmodule

// File: src/ign3_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ign3_blend: corner gradients and trilinear blend
// Gradients, then x, y and z interpolation stages, then scale and saturate.
// ----------------------------------------------------------------------------
module ign3_blend #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [7:0]                   in_hash [8],
    input  logic [FRAC_BITS-1:0]         in_fx,
    input  logic [FRAC_BITS-1:0]         in_fy,
    input  logic [FRAC_BITS-1:0]         in_fz,
    input  logic [FRAC_BITS:0]           in_u,
    input  logic [FRAC_BITS:0]           in_v,
    input  logic [FRAC_BITS:0]           in_w,
    output logic                         out_valid,
    output logic [ign3_pkg::OUT_W-1:0]   out_noise
);
    import ign3_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int GW = F + 3;          // gradient, |g| <= 2^(F+1)
    localparam int DW = GW + 1;         // differences
    localparam int PW = DW + F + 2;     // weight products
    localparam int SH = (F >= 16) ? F - 16 : 16 - F;
    localparam int RW = GW + 9;         // scaled result
    localparam logic signed [RW-1:0] MAXV = RW'(131071);
    localparam logic signed [RW-1:0] MINV = -RW'(131072);

    function automatic logic signed [GW-1:0] grad(
        input logic [3:0] h,
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] y,
        input logic signed [GW-1:0] z
    );
        logic signed [GW-1:0] u, v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [GW-1:0] lerp(
        input logic [F:0] w,
        input logic signed [GW-1:0] a,
        input logic signed [GW-1:0] b
    );
        logic signed [DW-1:0] d;
        logic signed [PW-1:0] p;
        d = DW'(b) - DW'(a);
        p = $signed({1'b0, w}) * d;
        return a + GW'(p >>> F);
    endfunction

    logic                 v_reg [4];
    logic signed [GW-1:0] g_reg [8];
    logic signed [GW-1:0] lx_reg [4];
    logic signed [GW-1:0] ly_reg [2];
    logic signed [GW-1:0] lz_reg;
    logic signed [RW-1:0] scl;
    logic [F:0]           u_reg, v1_reg, v2_reg, w1_reg, w2_reg, w3_reg;
    logic [OUT_W-1:0]     noise_reg;

    always_comb begin
        if (F >= 16) scl = RW'(lz_reg) >>> SH;
        else         scl = RW'(lz_reg) <<< SH;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [GW-1:0] x0, x1, y0, y1, z0, z1;
        if (en) begin
            x0 = GW'(in_fx);
            y0 = GW'(in_fy);
            z0 = GW'(in_fz);
            x1 = x0 - (GW'(1) <<< F);
            y1 = y0 - (GW'(1) <<< F);
            z1 = z0 - (GW'(1) <<< F);
            g_reg[0] <= grad(in_hash[0][3:0], x0, y0, z0);
            g_reg[1] <= grad(in_hash[1][3:0], x1, y0, z0);
            g_reg[2] <= grad(in_hash[2][3:0], x0, y1, z0);
            g_reg[3] <= grad(in_hash[3][3:0], x1, y1, z0);
            g_reg[4] <= grad(in_hash[4][3:0], x0, y0, z1);
            g_reg[5] <= grad(in_hash[5][3:0], x1, y0, z1);
            g_reg[6] <= grad(in_hash[6][3:0], x0, y1, z1);
            g_reg[7] <= grad(in_hash[7][3:0], x1, y1, z1);
            u_reg  <= in_u;
            v1_reg <= in_v;
            w1_reg <= in_w;
            for (int i = 0; i < 4; i++)
                lx_reg[i] <= lerp(u_reg, g_reg[2*i], g_reg[2*i+1]);
            v2_reg <= v1_reg;
            w2_reg <= w1_reg;
            ly_reg[0] <= lerp(v2_reg, lx_reg[0], lx_reg[1]);
            ly_reg[1] <= lerp(v2_reg, lx_reg[2], lx_reg[3]);
            w3_reg <= w2_reg;
            lz_reg <= lerp(w3_reg, ly_reg[0], ly_reg[1]);
        end
    end

    // output stage shares the stall enable
    always_ff @(posedge aclk) begin
        if (en) begin
            if (scl > MAXV)      noise_reg <= OUT_W'(MAXV);
            else if (scl < MINV) noise_reg <= OUT_W'(MINV);
            else                 noise_reg <= scl[OUT_W-1:0];
        end
    end

    logic vo_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vo_reg <= 1'b0;
        else if (en)  vo_reg <= v_reg[3];
    end

    assign out_valid = vo_reg;
    assign out_noise = noise_reg;

endmodule

// File: src/improved_gradient_noise_3d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// improved_gradient_noise_3d_unit: 3D improved gradient noise, Q16.16 in
// Streams one point per request through a fixed pipeline.
// ----------------------------------------------------------------------------
// Pipeline: 3 hash and 5 blend stages from input request to m_tvalid.
// Throughput: one point per cycle; a stalled output freezes the whole pipe,
// and s_tready follows m_tready or an empty output slot.
// Reset: synchronous active-low aresetn clears all valid bits; the
// permutation table is constant logic and needs no load.
module improved_gradient_noise_3d_unit #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata    // noise_value[17:0], zero pad [23:18]
);
    import ign3_pkg::*;

    // Pipeline advances when the output slot is empty or being drained.
    ign3_hs_t          hs;
    logic              h_valid;
    logic [7:0]        h_hash [8];
    logic [FRAC_BITS-1:0] h_fx, h_fy, h_fz;
    logic [FRAC_BITS:0]   h_u, h_v, h_w;
    logic [OUT_W-1:0]  noise;

    assign hs.valid = m_tvalid;
    assign hs.ready = m_tready;
    logic en;
    assign en = !hs.valid || hs.ready;
    assign s_tready = en;

    ign3_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid),
        .in_x(s_tdata[31:0]), .in_y(s_tdata[63:32]), .in_z(s_tdata[95:64]),
        .out_valid(h_valid), .out_hash(h_hash),
        .out_fx(h_fx), .out_fy(h_fy), .out_fz(h_fz),
        .out_u(h_u), .out_v(h_v), .out_w(h_w)
    );

    ign3_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(h_valid), .in_hash(h_hash),
        .in_fx(h_fx), .in_fy(h_fy), .in_fz(h_fz),
        .in_u(h_u), .in_v(h_v), .in_w(h_w),
        .out_valid(m_tvalid), .out_noise(noise)
    );

    assign m_tdata = {6'd0, noise};

endmodule

// File: src/ign3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ign3_checker: port-level checks for the noise unit
// Stall behavior, zero padding, ready and reset as seen on the stream ports.
// ----------------------------------------------------------------------------
module ign3_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [95:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:18] == 6'd0)
        else $error("pad bits set");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule

bind improved_gradient_noise_3d_unit ign3_checker u_ign3_checker (.*);

// File: sim/improved_gradient_noise_3d_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// improved_gradient_noise_3d_unit_test: self-checking bench for the noise unit
// Streams directed and random Q16.16 points through the unit and compares
// every noise sample with a fixed-point predictor, under several idle patterns.
// ----------------------------------------------------------------------------
module improved_gradient_noise_3d_unit_test;

    import ign3_pkg::*;

    localparam int FB       = 16;
    localparam int WD_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // noise_value[17:0], zero pad [23:18]

    improved_gradient_noise_3d_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // expected noise samples, oldest first
    logic [17:0] noise_q[$];
    int          err_cnt;
    int          req_cnt;
    int          rsp_cnt;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          idle_cnt;

    // Own copy of the standard permutation; the bench does not reuse the
    // package lookup for prediction.
    byte unsigned perm_tbl[256] = '{
        151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,
        69,142,8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,
        252,219,203,117,35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,
        168,68,175,74,165,71,134,139,48,27,166,77,146,158,231,83,111,229,122,60,
        211,133,230,220,105,92,41,55,46,245,40,244,102,143,54,65,25,63,161,1,
        216,80,73,209,76,132,187,208,89,18,169,200,196,135,130,116,188,159,86,
        164,100,109,198,173,186,3,64,52,217,226,250,124,123,5,202,38,147,118,
        126,255,82,85,212,207,206,59,227,47,16,58,17,182,189,28,42,223,183,170,
        213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,172,9,129,22,39,
        253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,228,251,34,
        242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,107,49,
        192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
        138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
    };

    function automatic int unsigned lattice(input int unsigned idx);
        return perm_tbl[idx & 8'hFF];   // doubled table wraps every 256
    endfunction

    function automatic longint fade_curve(input longint t);
        longint t2, t3, c;
        t2 = (t * t) >>> FB;
        t3 = (t2 * t) >>> FB;
        c  = 6 * t2 - 15 * t + 10 * (longint'(1) << FB);
        if (c < 0) c = 0;
        return (t3 * c) >>> FB;
    endfunction

    // arithmetic shift on longint is a floor toward minus infinity
    function automatic longint blend(input longint w, input longint a, input longint b);
        return a + ((w * (b - a)) >>> FB);
    endfunction

    function automatic longint corner_grad(input int unsigned hash, input longint x,
                                           input longint y, input longint z);
        int unsigned h;
        longint p, q;
        h = hash & 15;
        p = (h < 8) ? x : y;
        q = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return ((h & 1) ? -p : p) + ((h & 2) ? -q : q);
    endfunction

    function automatic logic [17:0] noise_at(input logic [31:0] cx, input logic [31:0] cy,
                                             input logic [31:0] cz);
        int unsigned xi, yi, zi, a, aa, ab, b, ba, bb;
        longint x, y, z, u, v, w, one, r;
        one = longint'(1) << FB;
        xi = cx[FB+7:FB]; yi = cy[FB+7:FB]; zi = cz[FB+7:FB];
        x = cx[FB-1:0]; y = cy[FB-1:0]; z = cz[FB-1:0];
        u = fade_curve(x); v = fade_curve(y); w = fade_curve(z);
        a = lattice(xi) + yi;     aa = lattice(a) + zi;   ab = lattice(a + 1) + zi;
        b = lattice(xi + 1) + yi; ba = lattice(b) + zi;   bb = lattice(b + 1) + zi;
        r = blend(w,
            blend(v,
                blend(u, corner_grad(lattice(aa), x, y, z),
                         corner_grad(lattice(ba), x - one, y, z)),
                blend(u, corner_grad(lattice(ab), x, y - one, z),
                         corner_grad(lattice(bb), x - one, y - one, z))),
            blend(v,
                blend(u, corner_grad(lattice(aa + 1), x, y, z - one),
                         corner_grad(lattice(ba + 1), x - one, y, z - one)),
                blend(u, corner_grad(lattice(ab + 1), x, y - one, z - one),
                         corner_grad(lattice(bb + 1), x - one, y - one, z - one))));
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r[17:0];
    endfunction

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [17:0] got,
                                   input logic [17:0] exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(exp), $time);
        err_cnt++;
    endtask

    // Receiver: random stalls, or a long hold-off counted in cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rsp_cnt++;
            if (noise_q.size() == 0) begin
                report_mismatch("unexpected noise sample", m_tdata[17:0], 'x);
            end else begin
                logic [17:0] exp;
                exp = noise_q.pop_front();
                if (m_tdata[17:0] !== exp)
                    report_mismatch("noise_value", m_tdata[17:0], exp);
            end
        end
    end

    // Watchdog: cycles with no request accepted on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // Offer one point, with a random idle gap first, and hold until accepted.
    // tvalid stays up afterwards; the next call or drain decides its level.
    task automatic send_point(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cz, cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        noise_q.push_back(noise_at(cx, cy, cz));
        req_cnt++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (noise_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return {{14{1'($urandom_range(1))}}, 18'($urandom())};   // near origin
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return {16'($urandom()), $urandom_range(1) ? 16'hFFFF : 16'h0000};
        endcase
    endfunction

    // Extremes, lattice points, negatives, wrap and fraction edges.
    task automatic test_directed;
        logic [31:0] pts[12] = '{32'h0, 32'h1, 32'hFFFF, 32'h10000, 32'h8000,
                                 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                                 32'hFFFF0000, 32'h00FF8000, 32'h01000001, 32'hAAAA5555};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 12; i++) send_point(pts[i], pts[(i + 5) % 12], pts[(i + 9) % 12]);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_point(32'h0000C000, 32'h0000C000, 32'h0000C000);
        send_point(32'h55555555, 32'hAAAAAAAA, 32'h00000000);
        drain();
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    // Receiver holds off while the sender keeps offering, filling the pipe.
    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 60;
        for (int i = 0; i < 40; i++) send_point(rand_coord(), rand_coord(), rand_coord());
        drain();   // sender pauses until every sample is back
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        err_cnt        = 0;
        req_cnt        = 0;
        rsp_cnt        = 0;
        idle_cnt       = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(400, 0, 0);
        test_random(350, 54, 0);
        test_random(350, 0, 54);
        test_random(350, 15, 15);
        test_backpressure();
        test_random(100, 0, 0);

        drain();
        repeat (20) @(posedge aclk);
        $display("Sent %0d points (lattice extremes, wrap, negatives, random) and",
                 req_cnt);
        $display("checked %0d noise samples under idle, stall and backpressure", rsp_cnt);
        if (err_cnt == 0 && noise_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
